>>> design/iau_pkg.sv
// shared constants and types for the integer arithmetic unit
package iau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPC_W          = 3;
    localparam int ST_W           = 2;

    localparam logic [OPC_W-1:0] OPC_ADD = 3'd0;
    localparam logic [OPC_W-1:0] OPC_SUB = 3'd1;
    localparam logic [OPC_W-1:0] OPC_MUL = 3'd2;
    localparam logic [OPC_W-1:0] OPC_DIV = 3'd3;
    localparam logic [OPC_W-1:0] OPC_POW = 3'd4;
    localparam logic [OPC_W-1:0] OPC_GCD = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV0   = 2'd1;
    localparam logic [ST_W-1:0] ST_NEGEXP = 2'd2;
    localparam logic [ST_W-1:0] ST_BADOP  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_POW_CHK,
        S_POW_ML,
        S_POW_SQ,
        S_GCD_TWO,
        S_GCD_RUN,
        S_GCD_FIX,
        S_DONE
    } state_t;

endpackage

>>> design/integer_arith_unit_with_power_gcd.sv
// integer arithmetic unit: add, sub, mul, div, power and gcd on a bit-serial datapath
//
// One transaction in gives one transaction out. Add, subtract and every error case
// (divide by zero, negative exponent, invalid opcode) go from acceptance straight to
// the done state, then to the output register once that register is free. Multiply
// runs one shift-add step per cycle and stops when the remaining multiplier
// bits are zero. Divide is a restoring divider with one quotient bit per cycle.
// Gcd is the binary algorithm with one shift or one subtract per cycle. Power is
// square-and-multiply on the same serial multiplier, with one square per exponent
// bit and one multiply per set exponent bit. The unit works on one transaction at
// a time; a new one is taken as soon as the previous result sits in the output
// register, even if that result has not been taken yet.
module integer_arith_unit_with_power_gcd #(
    parameter int DATA_WIDTH = iau_pkg::DATA_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // operand_a, operand_b, opcode, zero fill
    input  logic [((2*DATA_WIDTH+iau_pkg::OPC_W+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // result_value, status_code, zero fill
    output logic [((DATA_WIDTH+iau_pkg::ST_W+7)/8)*8-1:0]    m_tdata
);

    localparam int W     = DATA_WIDTH;
    localparam int CW    = $clog2(W + 1);
    localparam int OUT_W = ((W + iau_pkg::ST_W + 7) / 8) * 8;
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    iau_pkg::state_t state_reg, state_next;

    logic [W-1:0] a_in, b_in, abs_a, abs_b;
    logic [iau_pkg::OPC_W-1:0] opc_in;
    logic accept;

    logic [W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [W-1:0] mx_reg, mx_next, my_reg, my_next, mp_reg, mp_next;
    logic [W-1:0] res_reg, res_next;
    logic [iau_pkg::ST_W-1:0] st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next;
    logic out_valid_reg, out_valid_next;
    logic [W-1:0] out_val_reg, out_val_next;
    logic [iau_pkg::ST_W-1:0] out_st_reg, out_st_next;

    logic [W-1:0] mul_sum;
    logic [W:0]   rem_sh, div_diff;
    logic         div_ok;
    logic [W-1:0] q_new;
    logic         out_free;

    assign a_in   = s_tdata[W-1:0];
    assign b_in   = s_tdata[2*W-1:W];
    assign opc_in = s_tdata[2*W+iau_pkg::OPC_W-1:2*W];
    assign abs_a  = a_in[W-1] ? (~a_in + 1'b1) : a_in;
    assign abs_b  = b_in[W-1] ? (~b_in + 1'b1) : b_in;

    assign s_tready = (state_reg == iau_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // serial multiplier step
    assign mul_sum = mp_reg + (my_reg[0] ? mx_reg : '0);

    // restoring divider step: x holds dividend / quotient, z the remainder
    assign rem_sh   = {z_reg, x_reg[W-1]};
    assign div_diff = rem_sh - {1'b0, y_reg};
    assign div_ok   = !div_diff[W];
    assign q_new    = {x_reg[W-2:0], div_ok};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_st_reg, out_val_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iau_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opc_in)
                        iau_pkg::OPC_MUL: state_next = iau_pkg::S_MUL;
                        iau_pkg::OPC_DIV: state_next = (b_in == '0) ? iau_pkg::S_DONE
                                                                    : iau_pkg::S_DIV;
                        iau_pkg::OPC_POW: state_next = b_in[W-1] ? iau_pkg::S_DONE
                                                                 : iau_pkg::S_POW_CHK;
                        iau_pkg::OPC_GCD: state_next = iau_pkg::S_GCD_TWO;
                        default:          state_next = iau_pkg::S_DONE;
                    endcase
                end
            end
            iau_pkg::S_MUL:
                if (my_reg == '0) state_next = iau_pkg::S_DONE;
            iau_pkg::S_DIV:
                if (cnt_reg == LAST_BIT) state_next = iau_pkg::S_DONE;
            iau_pkg::S_POW_CHK:
            begin
                priority if (y_reg == '0) state_next = iau_pkg::S_DONE;
                else if (y_reg[0])        state_next = iau_pkg::S_POW_ML;
                else                      state_next = iau_pkg::S_POW_SQ;
            end
            iau_pkg::S_POW_ML:
                if (my_reg == '0) state_next = iau_pkg::S_POW_SQ;
            iau_pkg::S_POW_SQ:
                if (my_reg == '0) state_next = iau_pkg::S_POW_CHK;
            iau_pkg::S_GCD_TWO:
            begin
                priority if (x_reg == '0 || y_reg == '0) state_next = iau_pkg::S_DONE;
                else if (x_reg[0] || y_reg[0])           state_next = iau_pkg::S_GCD_RUN;
                else                                     state_next = iau_pkg::S_GCD_TWO;
            end
            iau_pkg::S_GCD_RUN:
                if (y_reg == '0) state_next = iau_pkg::S_GCD_FIX;
            iau_pkg::S_GCD_FIX:
                if (cnt_reg == '0) state_next = iau_pkg::S_DONE;
            iau_pkg::S_DONE:
                if (out_free) state_next = iau_pkg::S_IDLE;
            default: state_next = iau_pkg::S_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mp_next        = mp_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            iau_pkg::S_IDLE:
            begin
                res_next = '0;
                st_next  = iau_pkg::ST_OK;
                cnt_next = '0;
                mp_next  = '0;
                if (accept)
                begin
                    unique case (opc_in)
                        iau_pkg::OPC_ADD: res_next = a_in + b_in;
                        iau_pkg::OPC_SUB: res_next = a_in - b_in;
                        iau_pkg::OPC_MUL:
                        begin
                            mx_next = a_in;
                            my_next = b_in;
                        end
                        iau_pkg::OPC_DIV:
                        begin
                            if (b_in == '0)
                                st_next = iau_pkg::ST_DIV0;
                            x_next   = abs_a;
                            y_next   = abs_b;
                            z_next   = '0;
                            neg_next = a_in[W-1] ^ b_in[W-1];
                        end
                        iau_pkg::OPC_POW:
                        begin
                            if (b_in[W-1])
                                st_next = iau_pkg::ST_NEGEXP;
                            x_next = a_in;
                            y_next = b_in;
                            z_next = W'(1);
                        end
                        iau_pkg::OPC_GCD:
                        begin
                            x_next = abs_a;
                            y_next = abs_b;
                        end
                        default: st_next = iau_pkg::ST_BADOP;
                    endcase
                end
            end
            iau_pkg::S_MUL:
            begin
                if (my_reg == '0)
                    res_next = mp_reg;
                else
                begin
                    mp_next = mul_sum;
                    mx_next = {mx_reg[W-2:0], 1'b0};
                    my_next = {1'b0, my_reg[W-1:1]};
                end
            end
            iau_pkg::S_DIV:
            begin
                z_next   = div_ok ? div_diff[W-1:0] : rem_sh[W-1:0];
                x_next   = q_new;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                    res_next = neg_reg ? (~q_new + 1'b1) : q_new;
            end
            iau_pkg::S_POW_CHK:
            begin
                mp_next = '0;
                priority if (y_reg == '0)
                    res_next = z_reg;
                else if (y_reg[0])
                begin
                    mx_next = z_reg;
                    my_next = x_reg;
                end
                else
                begin
                    mx_next = x_reg;
                    my_next = x_reg;
                end
            end
            iau_pkg::S_POW_ML:
            begin
                if (my_reg == '0)
                begin
                    // acc done, start squaring the base
                    z_next  = mp_reg;
                    mx_next = x_reg;
                    my_next = x_reg;
                    mp_next = '0;
                end
                else
                begin
                    mp_next = mul_sum;
                    mx_next = {mx_reg[W-2:0], 1'b0};
                    my_next = {1'b0, my_reg[W-1:1]};
                end
            end
            iau_pkg::S_POW_SQ:
            begin
                if (my_reg == '0)
                begin
                    x_next = mp_reg;
                    y_next = {1'b0, y_reg[W-1:1]};
                end
                else
                begin
                    mp_next = mul_sum;
                    mx_next = {mx_reg[W-2:0], 1'b0};
                    my_next = {1'b0, my_reg[W-1:1]};
                end
            end
            iau_pkg::S_GCD_TWO:
            begin
                priority if (x_reg == '0)
                    res_next = y_reg;
                else if (y_reg == '0)
                    res_next = x_reg;
                else if (!x_reg[0] && !y_reg[0])
                begin
                    // strip common factors of two
                    x_next   = {1'b0, x_reg[W-1:1]};
                    y_next   = {1'b0, y_reg[W-1:1]};
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                    x_next = x_reg;
            end
            iau_pkg::S_GCD_RUN:
            begin
                priority if (y_reg == '0)
                    x_next = x_reg;
                else if (!x_reg[0])
                    x_next = {1'b0, x_reg[W-1:1]};
                else if (!y_reg[0])
                    y_next = {1'b0, y_reg[W-1:1]};
                else if (x_reg > y_reg)
                begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end
                else
                    y_next = y_reg - x_reg;
            end
            iau_pkg::S_GCD_FIX:
            begin
                if (cnt_reg == '0)
                    res_next = x_reg;
                else
                begin
                    x_next   = {x_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            iau_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = (st_reg == iau_pkg::ST_OK) ? res_reg : '0;
                    out_st_next    = st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iau_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        mp_reg      <= mp_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        neg_reg     <= neg_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    // an accepted transaction always starts work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("unit still ready after accepting a transaction");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg != iau_pkg::ST_OK) |-> (out_val_reg == '0))
        else $error("error status with nonzero result");

    // divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iau_pkg::S_DIV) |-> (y_reg != '0))
        else $error("divide step with zero divisor");

    // exponent stays non-negative through power
    a_pow_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iau_pkg::S_POW_CHK || state_reg == iau_pkg::S_POW_ML
         || state_reg == iau_pkg::S_POW_SQ) |-> !y_reg[W-1])
        else $error("negative exponent inside power loop");

    // output register is loaded only from the done state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == iau_pkg::S_DONE))
        else $error("result loaded outside done state");

endmodule
